[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SVAU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define SVAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

[design/svau_pkg.sv]
// Package: shared types, widths and the arctangent table of the vector angle unit.
`timescale 1ns / 1ps
`default_nettype none
package svau_pkg;

   localparam int SQ_STEPS     = 31;  // one root bit per stage, bits 30..0
   localparam int CORDIC_STEPS = 30;
   localparam int N_W          = 62;  // sqrt remainder and root width
   localparam int X_W          = 31;  // signed Q30 cosine
   localparam int Y_W          = 31;  // unsigned Q30 sine
   localparam int CW           = 34;  // cordic datapath width

   // per-turn 2^32 arctangents, rounded
   localparam logic [29:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1
   };

   typedef struct packed {
      logic valid;
      logic sat_neg;   // dot at or below -1: half turn
      logic sat_pos;   // dot at or above 1: zero
      logic flip;      // reference test negative
   } svau_side_type;

endpackage
`default_nettype wire

[design/signed_vector_angle_unit.sv]
// Top level: signed angle between two unit vectors, acos via sqrt and CORDIC.
//
// Usage: a request carries vectors a and b and an optional reference axis
// (req_ref_present). The result rsp_angle is acos(a.b) in binary angle units,
// 65536 per turn; a dot product at or below -1 gives 0x8000, at or above 1
// gives 0. With a reference present and ref.(a x b) negative the angle is
// mirrored to 65536 minus the angle.
// Throughput: one request per cycle while the receiver does not stall. The
// path has 68 register stages: five stages of products and sums, 31 stages
// of square root (one root bit each), 31 CORDIC stages (pre-rotation plus
// 30 iterations) and the output register.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; while the receiver stalls every stage holds and req_ready is
// low, so nothing is lost or repeated.
// Reset clears all stage valid bits and side flags; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module signed_vector_angle_unit
   import svau_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_a_x,
   input  wire logic signed [15:0] req_a_y,
   input  wire logic signed [15:0] req_a_z,
   input  wire logic signed [15:0] req_b_x,
   input  wire logic signed [15:0] req_b_y,
   input  wire logic signed [15:0] req_b_z,
   input  wire logic signed [15:0] req_ref_x,
   input  wire logic signed [15:0] req_ref_y,
   input  wire logic signed [15:0] req_ref_z,
   input  wire logic               req_ref_present,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [16:0]             rsp_angle
);

   localparam int TWO_F = 2 * FRAC_BITS;
   localparam int SH_R  = (TWO_F >= 30) ? (TWO_F - 30) : 0;
   localparam int SH_L  = (TWO_F < 30) ? (30 - TWO_F) : 0;
   localparam logic signed [63:0] UNIT2 = 64'sd1 <<< TWO_F;

   logic               rsp_valid_ff, rsp_valid_in;
   logic en;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 1: products
   logic v1_ff;
   logic signed [31:0] pd0_ff, pd1_ff, pd2_ff;
   logic signed [31:0] pc0_ff, pc1_ff, pc2_ff, pc3_ff, pc4_ff, pc5_ff;
   logic signed [15:0] rx1_ff, ry1_ff, rz1_ff;
   logic               rp1_ff;

   // stage 2: dot and cross
   logic v2_ff;
   logic signed [33:0] dot2_ff;
   logic signed [32:0] cx2_ff, cy2_ff, cz2_ff;
   logic signed [15:0] rx2_ff, ry2_ff, rz2_ff;
   logic               rp2_ff;

   // stage 3: saturation, Q30 cosine, reference products
   logic v3_ff;
   logic sn3_ff, sp3_ff, rp3_ff;
   logic [29:0]        mag3_ff;
   logic signed [X_W-1:0] x3_ff;
   logic signed [48:0] rc0_ff, rc1_ff, rc2_ff;
   logic signed [63:0] dot_ext;
   logic [33:0]        dot_abs;
   logic [63:0]        mag_q;
   logic signed [X_W-1:0] x3_in;

   // stage 4: square, reference sign
   logic v4_ff;
   logic sn4_ff, sp4_ff, fl4_ff;
   logic [59:0]        sq4_ff;
   logic signed [X_W-1:0] x4_ff;
   logic signed [50:0] rsum;

   // stage 5: radicand
   svau_side_type      side5_ff;
   logic [N_W-2:0]     n5_ff;
   logic signed [X_W-1:0] x5_ff;

   logic [Y_W-1:0]        sq_root;
   logic signed [X_W-1:0] sq_x;
   svau_side_type         sq_side;
   logic signed [CW-1:0]  cz;
   svau_side_type         cz_side;

   logic [16:0]        rsp_angle_ff, rsp_angle_in;
   logic [30:0]        z_clamp;
   logic [16:0]        ang;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         side5_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         side5_ff     <= '{valid: v4_ff, sat_neg: sn4_ff, sat_pos: sp4_ff, flip: fl4_ff};
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      dot_ext = {{30{dot2_ff[33]}}, dot2_ff};
      dot_abs = dot2_ff[33] ? 34'(-dot2_ff) : 34'(dot2_ff);
      mag_q   = ({30'b0, dot_abs} >> SH_R) << SH_L;
      x3_in   = dot2_ff[33] ? -$signed({1'b0, mag_q[29:0]}) : $signed({1'b0, mag_q[29:0]});
      rsum    = rc0_ff + rc1_ff + rc2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pd0_ff <= req_a_x * req_b_x;
         pd1_ff <= req_a_y * req_b_y;
         pd2_ff <= req_a_z * req_b_z;
         pc0_ff <= req_a_y * req_b_z;
         pc1_ff <= req_a_z * req_b_y;
         pc2_ff <= req_a_z * req_b_x;
         pc3_ff <= req_a_x * req_b_z;
         pc4_ff <= req_a_x * req_b_y;
         pc5_ff <= req_a_y * req_b_x;
         rx1_ff <= req_ref_x;
         ry1_ff <= req_ref_y;
         rz1_ff <= req_ref_z;
         rp1_ff <= req_ref_present;

         dot2_ff <= 34'(pd0_ff) + 34'(pd1_ff) + 34'(pd2_ff);
         cx2_ff  <= 33'(pc0_ff) - 33'(pc1_ff);
         cy2_ff  <= 33'(pc2_ff) - 33'(pc3_ff);
         cz2_ff  <= 33'(pc4_ff) - 33'(pc5_ff);
         rx2_ff  <= rx1_ff;
         ry2_ff  <= ry1_ff;
         rz2_ff  <= rz1_ff;
         rp2_ff  <= rp1_ff;

         sn3_ff  <= (dot_ext <= -UNIT2);
         sp3_ff  <= (dot_ext >= UNIT2);
         mag3_ff <= mag_q[29:0];
         x3_ff   <= x3_in;
         rc0_ff  <= rx2_ff * cx2_ff;
         rc1_ff  <= ry2_ff * cy2_ff;
         rc2_ff  <= rz2_ff * cz2_ff;
         rp3_ff  <= rp2_ff;

         sn4_ff  <= sn3_ff;
         sp4_ff  <= sp3_ff;
         fl4_ff  <= rp3_ff && rsum[50];
         sq4_ff  <= mag3_ff * mag3_ff;
         x4_ff   <= x3_ff;

         n5_ff   <= {1'b1, 60'b0} - {1'b0, sq4_ff};
         x5_ff   <= x4_ff;

         rsp_angle_ff <= rsp_angle_in;
      end
   end

   svau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .n        (n5_ff),
      .x        (x5_ff),
      .side     (side5_ff),
      .root     (sq_root),
      .x_out    (sq_x),
      .side_out (sq_side)
   );

   svau_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .x        (sq_x),
      .y        (sq_root),
      .side     (sq_side),
      .z        (cz),
      .side_out (cz_side)
   );

   always_comb begin
      if (cz[CW-1]) begin
         z_clamp = '0;
      end else if (cz[CW-2:31] != '0) begin
         z_clamp = '1;
      end else begin
         z_clamp = cz[30:0];
      end
      ang = {2'b0, z_clamp[30:16]};
      rsp_valid_in = cz_side.valid;
      if (cz_side.sat_neg) begin
         rsp_angle_in = 17'h08000;
      end else if (cz_side.sat_pos) begin
         rsp_angle_in = '0;
      end else if (cz_side.flip) begin
         rsp_angle_in = 17'h10000 - ang;
      end else begin
         rsp_angle_in = ang;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = rsp_angle_ff;

   `SVAU_ASSERT_NOW(a_angle_range, clock, reset, rsp_valid, rsp_angle <= 17'h10000)
   `SVAU_ASSERT_NOW(a_full_turn, clock, reset, rsp_valid && rsp_angle[16], rsp_angle[15:0] == 16'h0)
   `SVAU_ASSERT_NEXT(a_stall_freeze, clock, reset, !en, $stable(cz_side) && $stable(sq_side))

endmodule
`default_nettype wire

[design/svau_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module svau_sqrt
   import svau_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic [N_W-2:0]        n,
   input  wire logic signed [X_W-1:0] x,
   input  wire svau_side_type         side,
   output logic [Y_W-1:0]             root,
   output logic signed [X_W-1:0]      x_out,
   output svau_side_type              side_out
);

   logic [N_W-1:0]        n_pipe    [0:SQ_STEPS];
   logic [N_W-1:0]        root_pipe [0:SQ_STEPS];
   logic signed [X_W-1:0] x_pipe    [0:SQ_STEPS];
   svau_side_type         side_pipe [0:SQ_STEPS];

   logic [N_W-1:0]        n_ff    [0:SQ_STEPS-1];
   logic [N_W-1:0]        root_ff [0:SQ_STEPS-1];
   logic signed [X_W-1:0] x_ff    [0:SQ_STEPS-1];
   svau_side_type         side_ff [0:SQ_STEPS-1];

   assign n_pipe[0]    = {1'b0, n};
   assign root_pipe[0] = '0;
   assign x_pipe[0]    = x;
   assign side_pipe[0] = side;

   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
      localparam logic [N_W-1:0] BIT = {{(N_W-1){1'b0}}, 1'b1} << (2 * (SQ_STEPS - 1 - s));
      logic [N_W-1:0] trial;
      logic           take;
      logic [N_W-1:0] n_in;
      logic [N_W-1:0] root_in;

      always_comb begin
         trial   = root_pipe[s] + BIT;
         take    = (n_pipe[s] >= trial);
         n_in    = take ? (n_pipe[s] - trial) : n_pipe[s];
         root_in = take ? ((root_pipe[s] >> 1) + BIT) : (root_pipe[s] >> 1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s] <= '0;
         end else if (en) begin
            side_ff[s] <= side_pipe[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[s]    <= n_in;
            root_ff[s] <= root_in;
            x_ff[s]    <= x_pipe[s];
         end
      end

      assign n_pipe[s+1]    = n_ff[s];
      assign root_pipe[s+1] = root_ff[s];
      assign x_pipe[s+1]    = x_ff[s];
      assign side_pipe[s+1] = side_ff[s];
   end

   assign root     = root_pipe[SQ_STEPS][Y_W-1:0];
   assign x_out    = x_pipe[SQ_STEPS];
   assign side_out = side_pipe[SQ_STEPS];

endmodule
`default_nettype wire

[design/svau_cordic.sv]
// Pipelined CORDIC vectoring: angle of (x, y), one iteration per register stage.
`timescale 1ns / 1ps
`default_nettype none
module svau_cordic
   import svau_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic signed [X_W-1:0] x,
   input  wire logic [Y_W-1:0]        y,
   input  wire svau_side_type         side,
   output logic signed [CW-1:0]       z,
   output svau_side_type              side_out
);

   logic signed [CW-1:0] x_pipe [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_pipe [0:CORDIC_STEPS];
   logic signed [CW-1:0] z_pipe [0:CORDIC_STEPS];
   svau_side_type        side_pipe [0:CORDIC_STEPS];

   logic signed [CW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] z_ff [0:CORDIC_STEPS];
   svau_side_type        side_ff [0:CORDIC_STEPS];

   // pre-rotation by a quarter turn for the left half plane
   logic signed [CW-1:0] xe;
   logic signed [CW-1:0] ye;
   logic signed [CW-1:0] x0_in;
   logic signed [CW-1:0] y0_in;
   logic signed [CW-1:0] z0_in;

   always_comb begin
      xe = {{(CW-X_W){x[X_W-1]}}, x};
      ye = {{(CW-Y_W){1'b0}}, y};
      if (x[X_W-1]) begin
         x0_in = ye;
         y0_in = -xe;
         z0_in = CW'(64'sd1 <<< 30);
      end else begin
         x0_in = xe;
         y0_in = ye;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else if (en) begin
         side_ff[0] <= side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
      end
   end

   assign x_pipe[0]    = x_ff[0];
   assign y_pipe[0]    = y_ff[0];
   assign z_pipe[0]    = z_ff[0];
   assign side_pipe[0] = side_ff[0];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      localparam logic signed [CW-1:0] ATAN = {{(CW-30){1'b0}}, ATAN_TABLE[i]};
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [CW-1:0] z_in;

      always_comb begin
         xs = x_pipe[i] >>> i;
         ys = y_pipe[i] >>> i;
         if (y_pipe[i] > 0) begin
            x_in = x_pipe[i] + ys;
            y_in = y_pipe[i] - xs;
            z_in = z_pipe[i] + ATAN;
         end else begin
            x_in = x_pipe[i] - ys;
            y_in = y_pipe[i] + xs;
            z_in = z_pipe[i] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i+1] <= '0;
         end else if (en) begin
            side_ff[i+1] <= side_pipe[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end

      assign x_pipe[i+1]    = x_ff[i+1];
      assign y_pipe[i+1]    = y_ff[i+1];
      assign z_pipe[i+1]    = z_ff[i+1];
      assign side_pipe[i+1] = side_ff[i+1];
   end

   assign z        = z_pipe[CORDIC_STEPS];
   assign side_out = side_pipe[CORDIC_STEPS];

endmodule
`default_nettype wire
